// ===== rtl/refcounted_atom_table_assert.svh =====
// Assertion macros used by the checker file.
`ifndef REFCOUNTED_ATOM_TABLE_ASSERT_SVH
`define REFCOUNTED_ATOM_TABLE_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define RAT_ASSERT_IMPL(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define RAT_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

// ===== rtl/rat_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Atom table package
// Types, constants and helpers shared by the atom table modules.
// ----------------------------------------------------------------------------
package rat_pkg;
    localparam int SLOTS = 32;
    localparam int NAME_BYTES = 64;
    localparam int REF_BITS = 16;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int POS_W = $clog2(NAME_BYTES);
    localparam int ADDR_W = SLOT_W + POS_W;
    localparam logic [15:0] ATOM_BASE = 16'hC000;
    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_FIND = 2'd1;
    localparam logic [1:0] OP_GET = 2'd2;
    localparam logic [1:0] OP_DEL = 2'd3;

    typedef struct packed {
        logic [1:0]  operation;
        logic [7:0]  name_char;
        logic [15:0] atom_id;
        logic [6:0]  buffer_len;
    } in_beat_t;

    typedef struct packed {
        logic        out_kind;
        logic [7:0]  out_char;
        logic [15:0] answer;
        logic        last;
    } out_beat_t;

    function automatic logic [7:0] fold(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A)
        begin
            r = c + 8'd32;
        end
        return r;
    endfunction
endpackage

// ===== rtl/rat_name_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Atom table name memory
// Single-port byte memory with registered read data for the stored names.
// ----------------------------------------------------------------------------
module rat_name_ram (
    input  logic                       clk,
    input  logic                       we,
    input  logic [rat_pkg::ADDR_W-1:0] addr,
    input  logic [7:0]                 wdata,
    output logic [7:0]                 rdata
);
    logic [7:0] mem [rat_pkg::SLOTS*rat_pkg::NAME_BYTES];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// ===== rtl/refcounted_atom_table.sv =====
// A nonzero name beat scans the slots, one slot compared per cycle; a name end
// scans until a slot fully matches, else an add claims a free slot and a find
// answers zero; get name reads one character at a time; delete updates the
// count. The single name memory port sets this pace. One item is processed at a
// time; a result register holds each output beat. Reset clears slot flags,
// counts and name tracking; the name memory is not cleared.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Reference-counted atom table
// Interns names in a slot table and serves add, find, get name and delete.
// ----------------------------------------------------------------------------
module refcounted_atom_table (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  rat_pkg::in_beat_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output rat_pkg::out_beat_t out_data
);
    localparam int SW = rat_pkg::SLOT_W;
    localparam int PW = rat_pkg::POS_W;
    localparam logic [rat_pkg::REF_BITS-1:0] REF_ONE = rat_pkg::REF_BITS'(1);

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_END, S_GET, S_GETW, S_OUT
    } state_t;

    state_t state_reg;
    rat_pkg::in_beat_t item_reg;
    logic [rat_pkg::SLOTS-1:0] used_reg;
    logic [rat_pkg::REF_BITS-1:0] cnt_reg [rat_pkg::SLOTS];
    logic [rat_pkg::SLOTS-1:0] match_reg;
    logic [PW:0] pos_reg;
    logic [SW:0] free_reg;
    logic [SW:0] idx_reg;
    logic [PW:0] j_reg;
    logic out_valid_reg;
    rat_pkg::out_beat_t out_reg;

    logic ram_we;
    logic [rat_pkg::ADDR_W-1:0] ram_addr;
    logic [7:0] ram_wdata;
    logic [7:0] ram_rdata;

    rat_name_ram u_ram (
        .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
    );

    logic [SW:0] lowest_free;
    always_comb
    begin
        lowest_free = (SW+1)'(rat_pkg::SLOTS);
        for (int i = rat_pkg::SLOTS - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
            begin
                lowest_free = (SW+1)'(i);
            end
        end
    end

    logic [15:0] rel;
    logic atom_ok;
    assign rel = item_reg.atom_id - rat_pkg::ATOM_BASE;
    assign atom_ok = (item_reg.atom_id >= rat_pkg::ATOM_BASE) &&
                     (rel < 16'(rat_pkg::SLOTS)) && used_reg[rel[SW-1:0]];

    logic pos_in;
    assign pos_in = pos_reg < (PW+1)'(rat_pkg::NAME_BYTES);
    logic [PW-1:0] pos_cl;
    assign pos_cl = pos_in ? pos_reg[PW-1:0] : PW'(rat_pkg::NAME_BYTES - 1);

    always_comb
    begin
        ram_we = 1'b0;
        ram_wdata = 8'd0;
        ram_addr = {idx_reg[SW-1:0], pos_cl};
        if (state_reg == S_GET || state_reg == S_GETW)
        begin
            ram_addr = {rel[SW-1:0], j_reg[PW-1:0]};
        end
        if (state_reg == S_SCAN && idx_reg == (SW+1)'(rat_pkg::SLOTS))
        begin
            ram_addr = {free_reg[SW-1:0], pos_cl};
            ram_wdata = item_reg.name_char;
            ram_we = !free_reg[SW] && (pos_reg < (PW+1)'(rat_pkg::NAME_BYTES - 1));
        end
        if (state_reg == S_END && idx_reg == (SW+1)'(rat_pkg::SLOTS) &&
            item_reg.operation == rat_pkg::OP_ADD && !free_reg[SW])
        begin
            ram_addr = {free_reg[SW-1:0], pos_cl};
            ram_we = 1'b1;
        end
    end

    assign in_stall = (state_reg != S_IDLE) || out_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data = out_reg;

    logic [SW-1:0] pslot;
    assign pslot = SW'(idx_reg - 1'b1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            used_reg <= '0;
            for (int i = 0; i < rat_pkg::SLOTS; i++)
            begin
                cnt_reg[i] <= '0;
            end
            match_reg <= '1;
            pos_reg <= '0;
            free_reg <= '0;
            idx_reg <= '0;
            j_reg <= '0;
            out_valid_reg <= 1'b0;
            item_reg <= '0;
            out_reg <= '0;
        end
        else
        begin
            if (out_valid_reg && !out_stall && state_reg != S_GETW)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && !in_stall)
                    begin
                        item_reg <= in_data;
                        idx_reg <= '0;
                        j_reg <= '0;
                        if (in_data.operation == rat_pkg::OP_ADD ||
                            in_data.operation == rat_pkg::OP_FIND)
                        begin
                            if (pos_reg == '0)
                            begin
                                free_reg <= lowest_free;
                            end
                            state_reg <= (in_data.name_char != 8'd0) ? S_SCAN : S_END;
                        end
                        else if (in_data.operation == rat_pkg::OP_GET)
                        begin
                            state_reg <= S_GET;
                        end
                        else
                        begin
                            state_reg <= S_OUT;
                        end
                    end
                end
                S_SCAN:
                begin
                    if (idx_reg != '0 && (!pos_in ||
                        rat_pkg::fold(ram_rdata) != rat_pkg::fold(item_reg.name_char)))
                    begin
                        match_reg[pslot] <= 1'b0;
                    end
                    if (idx_reg == (SW+1)'(rat_pkg::SLOTS))
                    begin
                        if (pos_in)
                        begin
                            pos_reg <= pos_reg + 1'b1;
                        end
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_END:
                begin
                    if (idx_reg != '0 && pos_in && used_reg[pslot] &&
                        match_reg[pslot] && ram_rdata == 8'd0)
                    begin
                        if (item_reg.operation == rat_pkg::OP_ADD &&
                            cnt_reg[pslot] != '1)
                        begin
                            cnt_reg[pslot] <= cnt_reg[pslot] + 1'b1;
                        end
                        out_reg <= '{1'b1, 8'd0, rat_pkg::ATOM_BASE + 16'(pslot), 1'b1};
                        out_valid_reg <= 1'b1;
                        match_reg <= '1;
                        pos_reg <= '0;
                        free_reg <= '0;
                        state_reg <= S_IDLE;
                    end
                    else if (idx_reg == (SW+1)'(rat_pkg::SLOTS))
                    begin
                        if (item_reg.operation == rat_pkg::OP_ADD && !free_reg[SW])
                        begin
                            used_reg[free_reg[SW-1:0]] <= 1'b1;
                            cnt_reg[free_reg[SW-1:0]] <= REF_ONE;
                            out_reg <= '{1'b1, 8'd0,
                                rat_pkg::ATOM_BASE + 16'(free_reg[SW-1:0]), 1'b1};
                        end
                        else
                        begin
                            out_reg <= '{1'b1, 8'd0, 16'd0, 1'b1};
                        end
                        out_valid_reg <= 1'b1;
                        match_reg <= '1;
                        pos_reg <= '0;
                        free_reg <= '0;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_GET:
                begin
                    if (!atom_ok || item_reg.buffer_len == 7'd0)
                    begin
                        out_reg <= '{1'b1, 8'd0, 16'd0, 1'b1};
                        out_valid_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        state_reg <= S_GETW;
                    end
                end
                S_GETW:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        if ((7'(j_reg) + 7'd1) < item_reg.buffer_len &&
                            j_reg < (PW+1)'(rat_pkg::NAME_BYTES - 1) && ram_rdata != 8'd0)
                        begin
                            out_reg <= '{1'b0, ram_rdata, 16'd0, 1'b0};
                            out_valid_reg <= 1'b1;
                            j_reg <= j_reg + 1'b1;
                            state_reg <= S_GET;
                        end
                        else
                        begin
                            out_reg <= '{1'b1, 8'd0, 16'(j_reg), 1'b1};
                            out_valid_reg <= 1'b1;
                            state_reg <= S_IDLE;
                        end
                    end
                end
                S_OUT:
                begin
                    if (!atom_ok)
                    begin
                        out_reg <= '{1'b1, 8'd0, item_reg.atom_id, 1'b1};
                    end
                    else
                    begin
                        if (cnt_reg[rel[SW-1:0]] <= REF_ONE)
                        begin
                            used_reg[rel[SW-1:0]] <= 1'b0;
                        end
                        if (cnt_reg[rel[SW-1:0]] != '0)
                        begin
                            cnt_reg[rel[SW-1:0]] <= cnt_reg[rel[SW-1:0]] - 1'b1;
                        end
                        out_reg <= '{1'b1, 8'd0, 16'd0, 1'b1};
                    end
                    out_valid_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end
endmodule

// ===== rtl/rat_checker.sv =====
`timescale 1ns / 1ps
`include "refcounted_atom_table_assert.svh"
// ----------------------------------------------------------------------------
// Atom table port checker
// Checks port behavior of the atom table over time.
// ----------------------------------------------------------------------------
module rat_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input rat_pkg::in_beat_t  in_data,
    input logic               out_valid,
    input logic               out_stall,
    input rat_pkg::out_beat_t out_data
);
    `RAT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data))
    `RAT_ASSERT_IMPL(a_char_kind, clk, rst_n, out_valid && !out_data.out_kind, !out_data.last && out_data.answer == 16'd0)
    `RAT_ASSERT_IMPL(a_final_last, clk, rst_n, out_valid && out_data.out_kind, out_data.last && out_data.out_char == 8'd0)
    `RAT_ASSERT_IMPL(a_stall_busy, clk, rst_n, out_valid, in_stall)
endmodule

bind refcounted_atom_table rat_checker u_rat_checker (.*);
